/* src/pid_pkg.sv */
// ----------------------------------------------------------------------------
// pid_pkg
// Shared widths, register codes, reset values and the stage record of the
// PID step block.
// ----------------------------------------------------------------------------
package pid_pkg;

   localparam int ErrW    = 24;   // error sample
   localparam int DiffW   = 25;   // per-sample difference
   localparam int IntegW  = 48;   // saturating integral
   localparam int GainW   = 32;   // Q16.16 gains
   localparam int ETolW   = 23;
   localparam int DTolW   = 24;
   localparam int LimitW  = 31;
   localparam int DriveW  = 32;
   localparam int CsrIdxW = 3;
   localparam int CsrDataW = 32;

   // Magnitude cap of the integral term, as a power of two.
   localparam int TermCapLog2 = 58;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_GAIN_P          = 3'd0,
      CSR_GAIN_I          = 3'd1,
      CSR_GAIN_D          = 3'd2,
      CSR_ERROR_TOL       = 3'd3,
      CSR_DIFFERENCE_TOL  = 3'd4,
      CSR_INTEGRATE_MIN   = 3'd5,
      CSR_INTEGRATE_MAX   = 3'd6,
      CSR_OUTPUT_LIMIT    = 3'd7
   } csr_index_type;

   localparam logic [ErrW-1:0]   IntegMinReset    = 24'h80_0000;
   localparam logic [ErrW-1:0]   IntegMaxReset    = 24'h7F_FFFF;
   localparam logic [LimitW-1:0] OutputLimitReset = 31'h4000_0000;

   // One sample after the loop state update.
   typedef struct packed {
      logic signed [ErrW-1:0]   error;
      logic signed [DiffW-1:0]  diff;
      logic signed [IntegW-1:0] integ;
      logic                     at_setpoint;
   } sample_type;

endpackage

/* src/pid_state.sv */
// ----------------------------------------------------------------------------
// pid_state
// Loop state of the PID step: previous error, first-sample flag and the
// saturating integral with its window and sign-change clear.
// ----------------------------------------------------------------------------
module pid_state (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  take,
   input  logic signed [pid_pkg::ErrW-1:0]       error_sample,
   input  logic signed [pid_pkg::ErrW-1:0]       integrate_min,
   input  logic signed [pid_pkg::ErrW-1:0]       integrate_max,
   input  logic        [pid_pkg::ETolW-1:0]      error_tolerance,
   input  logic        [pid_pkg::DTolW-1:0]      difference_tolerance,
   output pid_pkg::sample_type                   sample
);
   import pid_pkg::*;

   logic signed [ErrW-1:0]   prev_err_ff;
   logic                     have_prev_ff;
   logic signed [IntegW-1:0] integ_ff;

   logic signed [DiffW-1:0]  diff;
   logic signed [IntegW:0]   integ_wide;
   logic signed [IntegW-1:0] integ_sat;
   logic signed [IntegW-1:0] integ_in;
   logic                     in_window;
   logic                     sign_same;
   logic        [ErrW-1:0]   mag_err;
   logic        [DiffW-1:0]  mag_diff;

   always_comb begin
      diff = have_prev_ff
           ? ($signed({error_sample[ErrW-1], error_sample})
              - $signed({prev_err_ff[ErrW-1], prev_err_ff}))
           : '0;

      in_window = (prev_err_ff >= integrate_min) && (prev_err_ff <= integrate_max);

      integ_wide = $signed({integ_ff[IntegW-1], integ_ff})
                 + $signed((IntegW+1)'(prev_err_ff));
      if (integ_wide[IntegW] != integ_wide[IntegW-1]) begin
         // Overflow: saturate toward the sign of the true sum.
         integ_sat = integ_wide[IntegW] ? {1'b1, {(IntegW-1){1'b0}}}
                                        : {1'b0, {(IntegW-1){1'b1}}};
      end else begin
         integ_sat = integ_wide[IntegW-1:0];
      end

      // Signs compared as -1, 0, +1.
      sign_same = ((error_sample == '0) && (prev_err_ff == '0))
               || ((error_sample != '0) && (prev_err_ff != '0)
                   && (error_sample[ErrW-1] == prev_err_ff[ErrW-1]));

      if (!have_prev_ff) begin
         integ_in = integ_ff;
      end else if (!in_window || !sign_same) begin
         integ_in = '0;
      end else begin
         integ_in = integ_sat;
      end

      mag_err  = error_sample[ErrW-1] ? (ErrW)'(-error_sample) : error_sample;
      mag_diff = diff[DiffW-1] ? (DiffW)'(-diff) : diff;

      sample.error       = error_sample;
      sample.diff        = diff;
      sample.integ       = integ_in;
      sample.at_setpoint = (mag_err < {1'b0, error_tolerance})
                        && (mag_diff < {1'b0, difference_tolerance});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_err_ff  <= '0;
         have_prev_ff <= 1'b0;
         integ_ff     <= '0;
      end else if (take) begin
         prev_err_ff  <= error_sample;
         have_prev_ff <= 1'b1;
         integ_ff     <= integ_in;
      end
   end

endmodule

/* src/pid_controller_step.sv */
// ----------------------------------------------------------------------------
// pid_controller_step
// PID controller step with Q16.16 gains, integrator window and clamp.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                     Direction  Moves
//  req       req_valid/req_ready, req_error_sample     in         one error sample
//  rsp       rsp_valid/rsp_ready, rsp_drive, flags     out        one drive result
//  csr       csr_we, csr_index, csr_wdata              in         register write
//
//  A sample can be accepted in every cycle while rsp is not stalled; each
//  transfer on req gives exactly one transfer on rsp, through A, B, C and out.
//  The loop state (previous error, integral) is updated in the acceptance
//  cycle, so consecutive samples never wait on each other.
//  The pipeline holds up to four samples (stage A, products, terms, output);
//  a stall on rsp fills the empty stages first and then drops req_ready.
//  Reset is synchronous and active high; it clears the loop state, the valid
//  bits and the configuration registers to their documented values.
//
module pid_controller_step (
   input  logic                                   clock,
   input  logic                                   reset,
   // sample input
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [pid_pkg::ErrW-1:0]        req_error_sample,
   // drive output
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [pid_pkg::DriveW-1:0]      rsp_drive,
   output logic                                   rsp_at_setpoint,
   output logic                                   rsp_clamped,
   // configuration writes
   input  logic                                   csr_we,
   input  logic        [pid_pkg::CsrIdxW-1:0]     csr_index,
   input  logic        [pid_pkg::CsrDataW-1:0]    csr_wdata
);
   import pid_pkg::*;

   localparam int PeW   = GainW + ErrW;       // kp * e
   localparam int PdW   = GainW + DiffW;      // kd * diff
   localparam int PhW   = GainW + ErrW;       // ki * upper integral half
   localparam int PlW   = GainW + ErrW + 1;   // ki * lower integral half
   localparam int LoW   = IntegW - ErrW;      // width of the lower half
   localparam int FullW = PhW + LoW + 1;      // exact ki * integral
   localparam int TermW = TermCapLog2 + 2;    // capped integral term
   localparam int PdeW  = PdW + 1;            // kp*e + kd*diff
   localparam int SumW  = TermW;
   localparam int RawW  = SumW - 16;          // floored integer part

   localparam logic signed [FullW-1:0] CapPos = FullW'(1) <<< TermCapLog2;
   localparam logic signed [FullW-1:0] CapNeg = -CapPos;

   // Configuration registers.
   logic signed [GainW-1:0]  gain_p_ff, gain_i_ff, gain_d_ff;
   logic        [ETolW-1:0]  error_tol_ff;
   logic        [DTolW-1:0]  diff_tol_ff;
   logic signed [ErrW-1:0]   integ_min_ff, integ_max_ff;
   logic        [LimitW-1:0] output_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff       <= '0;
         gain_i_ff       <= '0;
         gain_d_ff       <= '0;
         error_tol_ff    <= '0;
         diff_tol_ff     <= '0;
         integ_min_ff    <= IntegMinReset;
         integ_max_ff    <= IntegMaxReset;
         output_limit_ff <= OutputLimitReset;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_GAIN_P:         gain_p_ff       <= csr_wdata;
            CSR_GAIN_I:         gain_i_ff       <= csr_wdata;
            CSR_GAIN_D:         gain_d_ff       <= csr_wdata;
            CSR_ERROR_TOL:      error_tol_ff    <= csr_wdata[ETolW-1:0];
            CSR_DIFFERENCE_TOL: diff_tol_ff     <= csr_wdata[DTolW-1:0];
            CSR_INTEGRATE_MIN:  integ_min_ff    <= csr_wdata[ErrW-1:0];
            CSR_INTEGRATE_MAX:  integ_max_ff    <= csr_wdata[ErrW-1:0];
            CSR_OUTPUT_LIMIT:   output_limit_ff <= csr_wdata[LimitW-1:0];
         endcase
      end
   end

   // Pipeline flow control. Each stage moves on when the next one is empty
   // or moving itself, so bubbles close up under a stalled output.
   logic a_vld_ff, b_vld_ff, c_vld_ff, rsp_valid_ff;
   logic out_open, c_open, b_open, a_open;
   logic a_load, b_load, c_load, out_load;

   assign out_open  = !rsp_valid_ff || rsp_ready;
   assign c_open    = !c_vld_ff || out_open;
   assign b_open    = !b_vld_ff || c_open;
   assign a_open    = !a_vld_ff || b_open;
   assign req_ready = a_open;

   assign a_load   = req_valid && a_open;
   assign b_load   = a_vld_ff && b_open;
   assign c_load   = b_vld_ff && c_open;
   assign out_load = c_vld_ff && out_open;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff     <= 1'b0;
         b_vld_ff     <= 1'b0;
         c_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_vld_ff     <= a_load   || (a_vld_ff && !b_open);
         b_vld_ff     <= b_load   || (b_vld_ff && !c_open);
         c_vld_ff     <= c_load   || (c_vld_ff && !out_open);
         rsp_valid_ff <= out_load || (rsp_valid_ff && !rsp_ready);
      end
   end

   // Stage A: loop state update at acceptance.
   sample_type a_in, a_ff;

   pid_state u_state (
      .clock                (clock),
      .reset                (reset),
      .take                 (a_load),
      .error_sample         (req_error_sample),
      .integrate_min        (integ_min_ff),
      .integrate_max        (integ_max_ff),
      .error_tolerance      (error_tol_ff),
      .difference_tolerance (diff_tol_ff),
      .sample               (a_in)
   );

   always_ff @(posedge clock) begin
      if (a_load) begin
         a_ff <= a_in;
      end
   end

   // Stage B: the four products. The 48-bit integral is split into a signed
   // upper half and an unsigned lower half so that no multiplier exceeds
   // 32 by 25 bits.
   logic signed [PeW-1:0] pe_in, pe_ff;
   logic signed [PdW-1:0] pd_in, pd_ff;
   logic signed [PhW-1:0] ph_in, ph_ff;
   logic signed [PlW-1:0] pl_in, pl_ff;
   logic signed [ErrW-1:0] integ_hi;
   logic signed [LoW:0]    integ_lo;
   logic                   b_setp_ff;

   always_comb begin
      integ_hi = a_ff.integ[IntegW-1:LoW];
      integ_lo = $signed({1'b0, a_ff.integ[LoW-1:0]});
      pe_in    = gain_p_ff * a_ff.error;
      pd_in    = gain_d_ff * a_ff.diff;
      ph_in    = gain_i_ff * integ_hi;
      pl_in    = gain_i_ff * integ_lo;
   end

   always_ff @(posedge clock) begin
      if (b_load) begin
         pe_ff     <= pe_in;
         pd_ff     <= pd_in;
         ph_ff     <= ph_in;
         pl_ff     <= pl_in;
         b_setp_ff <= a_ff.at_setpoint;
      end
   end

   // Stage C: rebuild ki * integral exactly, cap it at plus or minus 2^58,
   // and add the proportional and derivative terms.
   logic signed [FullW-1:0] full_prod;
   logic signed [TermW-1:0] term_in, term_ff;
   logic signed [PdeW-1:0]  pde_in, pde_ff;
   logic                    c_setp_ff;

   always_comb begin
      full_prod = $signed({ph_ff[PhW-1], ph_ff, {LoW{1'b0}}}) + FullW'(pl_ff);
      if (full_prod > CapPos) begin
         term_in = CapPos[TermW-1:0];
      end else if (full_prod < CapNeg) begin
         term_in = CapNeg[TermW-1:0];
      end else begin
         term_in = full_prod[TermW-1:0];
      end
      pde_in = PdeW'(pe_ff) + PdeW'(pd_ff);
   end

   always_ff @(posedge clock) begin
      if (c_load) begin
         term_ff   <= term_in;
         pde_ff    <= pde_in;
         c_setp_ff <= b_setp_ff;
      end
   end

   // Output stage: total sum, floor to an integer by dropping the fraction
   // bits, then clamp to plus or minus the output limit.
   logic signed [SumW-1:0]   sum;
   logic signed [RawW-1:0]   raw;
   logic signed [RawW-1:0]   lim_pos, lim_neg;
   logic signed [DriveW-1:0] rsp_drive_in, rsp_drive_ff;
   logic                     rsp_clamped_in, rsp_clamped_ff;
   logic                     rsp_setp_ff;

   always_comb begin
      sum     = term_ff + SumW'(pde_ff);
      raw     = sum[SumW-1:16];
      lim_pos = $signed(RawW'(output_limit_ff));
      lim_neg = -lim_pos;
      if (raw > lim_pos) begin
         rsp_drive_in   = lim_pos[DriveW-1:0];
         rsp_clamped_in = 1'b1;
      end else if (raw < lim_neg) begin
         rsp_drive_in   = lim_neg[DriveW-1:0];
         rsp_clamped_in = 1'b1;
      end else begin
         rsp_drive_in   = raw[DriveW-1:0];
         rsp_clamped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_drive_ff   <= rsp_drive_in;
         rsp_clamped_ff <= rsp_clamped_in;
         rsp_setp_ff    <= c_setp_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drive       = rsp_drive_ff;
   assign rsp_clamped     = rsp_clamped_ff;
   assign rsp_at_setpoint = rsp_setp_ff;

`ifndef SYNTHESIS
   // A clamped result sits exactly on one of the two limits.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_clamped) |->
         (rsp_drive == $signed({1'b0, output_limit_ff}))
         || (rsp_drive == -$signed({1'b0, output_limit_ff})))
      else $error("clamped result is not at the output limit");

   // Every result stays inside the output limit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_drive <= $signed({1'b0, output_limit_ff}))
         && (rsp_drive >= -$signed({1'b0, output_limit_ff})))
      else $error("drive outside the output limit");

   // A sample held in stage A keeps its contents while the next stage is full.
   assert property (@(posedge clock) disable iff (reset)
      (a_vld_ff && !b_open) |=> (a_vld_ff && $stable(a_ff)))
      else $error("stage A lost or changed a held sample");

   // A sample in the products stage cannot vanish without moving on.
   assert property (@(posedge clock) disable iff (reset)
      (b_vld_ff && !c_load) |=> b_vld_ff)
      else $error("products stage dropped a sample");
`endif

endmodule

/* bench/pid_controller_step_test.sv */
// ----------------------------------------------------------------------------
// pid_controller_step_test
// Self-checking bench for the PID step block. A behavioral copy of the
// control law runs on each accepted error sample and predicts the drive,
// at-setpoint and clamp flags. Each result transfer is checked in order
// against that prediction. Directed cases come first, then random register
// settings and runs with and without random input gaps and output stalls.
// ----------------------------------------------------------------------------
module pid_controller_step_test;
   timeunit 1ns;
   timeprecision 1ps;

   import pid_pkg::*;

   localparam int ClockHalf        = 5;
   localparam int ResetCycles      = 10;
   localparam int RegCount         = 2 ** CsrIdxW;
   // The watchdog limit is far above the longest legitimate quiet stretch:
   // the deliberate output hold plus a few idle bursts and the settle pause.
   localparam int WatchdogLimit    = 2000;
   localparam int OutputHoldCycles = 60;
   // The pipeline is four stages deep, so a few extra cycles cover it.
   localparam int SettleCycles     = 8;
   localparam int RandomPhases     = 8;
   localparam int PhaseSamples     = 50;
   localparam int FullRateSamples  = 40;

   localparam longint IntegralHigh = (longint'(1) <<< (IntegW - 1)) - 1;
   localparam longint IntegralLow  = -(longint'(1) <<< (IntegW - 1));
   localparam longint TermCap      = longint'(1) <<< TermCapLog2;

   typedef struct packed {
      logic signed [DriveW-1:0] drive;
      logic                     at_setpoint;
      logic                     clamped;
   } drive_result_type;

   // Every input has a known value from time zero.
   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic signed [ErrW-1:0]     req_error_sample = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [DriveW-1:0]   rsp_drive;
   logic                       rsp_at_setpoint;
   logic                       rsp_clamped;
   logic                       csr_we = 1'b0;
   logic [CsrIdxW-1:0]         csr_index = '0;
   logic [CsrDataW-1:0]        csr_wdata = '0;

   // Bench copy of the registers, starting at their reset values.
   logic signed [GainW-1:0]    gain_p = '0;
   logic signed [GainW-1:0]    gain_i = '0;
   logic signed [GainW-1:0]    gain_d = '0;
   logic [ETolW-1:0]           error_tol = '0;
   logic [DTolW-1:0]           diff_tol = '0;
   logic signed [ErrW-1:0]     window_lo = IntegMinReset;
   logic signed [ErrW-1:0]     window_hi = IntegMaxReset;
   logic [LimitW-1:0]          drive_limit = OutputLimitReset;

   // Bench copy of the loop state.
   logic signed [ErrW-1:0]     last_error = '0;
   bit                         have_last = 1'b0;
   logic signed [IntegW-1:0]   integral = '0;

   // Values staged for the next block of register writes, by register index.
   logic [CsrDataW-1:0]        register_image [RegCount];

   drive_result_type           pending_drives [$];

   int                         failures = 0;
   int                         samples_sent = 0;
   int                         settings_used = 0;
   int                         clamped_seen = 0;
   int                         setpoint_seen = 0;

   // Idle controls shared by the sender, the receiver and the tests.
   bit                         sender_idles = 1'b0;
   bit                         receiver_idles = 1'b0;
   bit                         hold_output = 1'b0;

   // State of the random sample generator: the current run style and its length.
   int                         run_left = 0;
   int                         run_style = 0;

   pid_controller_step dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_error_sample (req_error_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_drive        (rsp_drive),
      .rsp_at_setpoint  (rsp_at_setpoint),
      .rsp_clamped      (rsp_clamped),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #ClockHalf clock = 1'b1;
      #ClockHalf clock = 1'b0;
   end

   function automatic longint magnitude(longint x);
      return (x < 0) ? -x : x;
   endfunction

   function automatic int sign_of(longint x);
      return (x > 0) ? 1 : ((x < 0) ? -1 : 0);
   endfunction

   // Advances the loop state by one error sample and returns the result that
   // the block must produce for it.
   function automatic drive_result_type predict_drive(logic signed [ErrW-1:0] e);
      longint                 diff;
      longint                 acc;
      longint                 p_term;
      longint                 i_term;
      longint                 d_term;
      longint                 sum;
      longint                 drv;
      longint                 limit;
      logic signed [95:0]     ki_wide;
      logic signed [95:0]     integ_wide;
      logic signed [95:0]     i_product;
      drive_result_type       r;

      diff = 0;
      // The very first sample after reset has no predecessor: the difference
      // is zero and the integral is left alone.
      if (have_last) begin
         diff = longint'(e) - longint'(last_error);
         if (last_error >= window_lo && last_error <= window_hi) begin
            acc = longint'(integral) + longint'(last_error);
            if (acc > IntegralHigh) begin
               acc = IntegralHigh;
            end
            if (acc < IntegralLow) begin
               acc = IntegralLow;
            end
            integral = IntegW'(acc);
         end else begin
            integral = '0;
         end
         // A change of sign, zero counting as its own sign, clears the integral.
         if (sign_of(last_error) != sign_of(e)) begin
            integral = '0;
         end
      end
      last_error = e;
      have_last = 1'b1;

      p_term = longint'(gain_p) * longint'(e);
      ki_wide = 96'(gain_i);
      integ_wide = 96'(integral);
      i_product = ki_wide * integ_wide;
      if (i_product > TermCap) begin
         i_term = TermCap;
      end else if (i_product < -TermCap) begin
         i_term = -TermCap;
      end else begin
         i_term = longint'(i_product);
      end
      d_term = longint'(gain_d) * diff;

      // Floor of the Q16.16 sum, then the symmetric clamp.
      sum = p_term + i_term + d_term;
      drv = sum >>> 16;
      limit = longint'(drive_limit);
      r.clamped = 1'b0;
      if (drv > limit) begin
         drv = limit;
         r.clamped = 1'b1;
      end else if (drv < -limit) begin
         drv = -limit;
         r.clamped = 1'b1;
      end
      r.drive = DriveW'(drv);
      r.at_setpoint = (magnitude(e) < longint'(error_tol)) &&
                      (magnitude(diff) < longint'(diff_tol));
      return r;
   endfunction

   // Writes the staged values of the selected registers, one per cycle. It is
   // entered and left at a falling edge, with the block idle.
   task automatic program_registers(input logic [RegCount-1:0] which);
      csr_index_type idx;

      for (int i = 0; i < RegCount; i++) begin
         if (which[i]) begin
            idx = csr_index_type'(i);
            csr_we <= 1'b1;
            csr_index <= idx;
            csr_wdata <= register_image[i];
            @(posedge clock);
            case (idx)
               CSR_GAIN_P:         gain_p = register_image[i];
               CSR_GAIN_I:         gain_i = register_image[i];
               CSR_GAIN_D:         gain_d = register_image[i];
               CSR_ERROR_TOL:      error_tol = register_image[i][ETolW-1:0];
               CSR_DIFFERENCE_TOL: diff_tol = register_image[i][DTolW-1:0];
               CSR_INTEGRATE_MIN:  window_lo = register_image[i][ErrW-1:0];
               CSR_INTEGRATE_MAX:  window_hi = register_image[i][ErrW-1:0];
               CSR_OUTPUT_LIMIT:   drive_limit = register_image[i][LimitW-1:0];
               default: ;
            endcase
            @(negedge clock);
         end
      end
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // Offers one sample and returns at the falling edge after its transfer.
   // Valid stays high on return; the next call either changes the payload or
   // drops valid for an idle burst, so valid is assigned once per edge.
   task automatic send_sample(input logic signed [ErrW-1:0] e);
      int gap;

      if (sender_idles && $urandom_range(0, 2) == 0) begin
         gap = $urandom_range(1, 10);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_error_sample <= e;
      do @(posedge clock); while (!req_ready);
      pending_drives.push_back(predict_drive(e));
      samples_sent++;
      @(negedge clock);
   endtask

   // Stops offering samples and waits until every predicted result has been
   // checked, plus a few cycles so that the block is certainly idle.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_drives.size() != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   function automatic logic [CsrDataW-1:0] pick_gain();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return '0;
         // Small gains, within plus or minus three.
         3: return CsrDataW'(int'($urandom_range(0, 393216)) - 196608);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [CsrDataW-1:0] pick_bounded(int unsigned hi);
      case ($urandom_range(0, 4))
         0: return '0;
         1: return hi;
         2: return $urandom_range(0, 40);
         3: return $urandom_range(0, hi >> 8);
         default: return $urandom_range(0, hi);
      endcase
   endfunction

   function automatic void randomize_registers();
      int lo;
      int hi;
      int r;

      register_image[CSR_GAIN_P] = pick_gain();
      register_image[CSR_GAIN_I] = pick_gain();
      register_image[CSR_GAIN_D] = pick_gain();
      register_image[CSR_ERROR_TOL] = pick_bounded(32'h007F_FFFF);
      register_image[CSR_DIFFERENCE_TOL] = pick_bounded(32'h00FF_FFFF);
      register_image[CSR_OUTPUT_LIMIT] = pick_bounded(32'h7FFF_FFFF);
      case ($urandom_range(0, 3))
         0: begin
            lo = -(1 << 23);
            hi = (1 << 23) - 1;
         end
         1: begin
            r = $urandom_range(0, 64);
            lo = -r;
            hi = r;
         end
         2: begin
            // Empty window: nothing integrates.
            lo = $urandom_range(1, 1000);
            hi = -lo;
         end
         default: begin
            lo = int'($urandom_range(0, 24'hFF_FFFF)) - (1 << 23);
            hi = int'($urandom_range(0, 24'hFF_FFFF)) - (1 << 23);
         end
      endcase
      register_image[CSR_INTEGRATE_MIN] = lo;
      register_image[CSR_INTEGRATE_MAX] = hi;
   endfunction

   // Samples come in runs. Same-sign runs let the integral build up and are
   // the bulk of the traffic; full-range and extreme values are the noise
   // that breaks runs and exercises the sign-change clear.
   function automatic logic signed [ErrW-1:0] next_error();
      if (run_left == 0) begin
         run_style = $urandom_range(0, 6);
         run_left = $urandom_range(4, 30);
      end
      run_left--;
      case (run_style)
         0: return ErrW'($urandom());
         1: return ErrW'(int'($urandom_range(0, 32)) - 16);
         2: return ErrW'($urandom_range(1, 24'h7F_FFFF));
         3: return ErrW'(-int'($urandom_range(1, 24'h80_0000)));
         4: begin
            case ($urandom_range(0, 4))
               0: return 24'sh7F_FFFF;
               1: return 24'sh80_0000;
               2: return '0;
               3: return -24'sd1;
               default: return 24'sd1;
            endcase
         end
         5: return 24'sh7F_FFFF;
         default: return 24'sh80_0000;
      endcase
   endfunction

   // The first sample after reset has a zero difference, which the tight
   // difference tolerance reveals. The rest swing across the full error range
   // so that the difference reaches plus and minus (2^24 - 1) in 25 bits.
   task automatic test_first_sample_and_extremes();
      logic signed [ErrW-1:0] samples [9] = '{
         24'sd5, 24'sh7F_FFFF, 24'sh80_0000, 24'sh7F_FFFF, 24'sd0,
         -24'sd1, 24'sd1, 24'sd2, 24'sd2};

      register_image[CSR_GAIN_P] = 32'h7FFF_FFFF;
      register_image[CSR_GAIN_I] = 32'h8000_0000;
      register_image[CSR_GAIN_D] = 32'h8000_0000;
      register_image[CSR_ERROR_TOL] = 32'h007F_FFFF;
      register_image[CSR_DIFFERENCE_TOL] = 32'd3;
      register_image[CSR_INTEGRATE_MIN] = 32'hFF80_0000;
      register_image[CSR_INTEGRATE_MAX] = 32'h007F_FFFF;
      register_image[CSR_OUTPUT_LIMIT] = 32'h7FFF_FFFF;
      program_registers('1);
      foreach (samples[i]) begin
         send_sample(samples[i]);
      end
      wait_for_results();
   endtask

   // A narrow window of plus or minus four: an error of five is still added
   // as the new sample, but clears the integral on the step after it. The
   // tolerances sit right at the sample values to probe the strict compare,
   // and a small limit clamps in both directions.
   task automatic test_window_and_tolerances();
      logic signed [ErrW-1:0] samples [9] = '{
         24'sd3, 24'sd3, 24'sd4, 24'sd5, 24'sd6, 24'sd200, -24'sd200,
         -24'sd2, 24'sd0};

      register_image[CSR_GAIN_P] = 32'h0001_0000;
      register_image[CSR_GAIN_I] = 32'h0000_8000;
      register_image[CSR_GAIN_D] = 32'hFFFF_0000;
      register_image[CSR_ERROR_TOL] = 32'd3;
      register_image[CSR_DIFFERENCE_TOL] = 32'd2;
      register_image[CSR_INTEGRATE_MIN] = -32'sd4;
      register_image[CSR_INTEGRATE_MAX] = 32'd4;
      register_image[CSR_OUTPUT_LIMIT] = 32'd10;
      program_registers('1);
      foreach (samples[i]) begin
         send_sample(samples[i]);
      end
      wait_for_results();
   endtask

   // Window bounds crossed so that nothing integrates, and a zero limit that
   // forces every drive to zero.
   task automatic test_empty_window_zero_limit();
      logic signed [ErrW-1:0] samples [4] = '{24'sd2, 24'sd2, -24'sd7, 24'sd0};

      register_image[CSR_INTEGRATE_MIN] = 32'd5;
      register_image[CSR_INTEGRATE_MAX] = -32'sd5;
      register_image[CSR_OUTPUT_LIMIT] = '0;
      program_registers((RegCount'(1) << CSR_INTEGRATE_MIN) |
                        (RegCount'(1) << CSR_INTEGRATE_MAX) |
                        (RegCount'(1) << CSR_OUTPUT_LIMIT));
      foreach (samples[i]) begin
         send_sample(samples[i]);
      end
      wait_for_results();
   endtask

   // The receiver holds off for a long stretch while samples keep coming, so
   // the pipeline fills and req_ready must drop. A run of the largest error
   // with the largest integral gain also drives the integral term into its
   // magnitude cap.
   task automatic test_output_hold();
      register_image[CSR_GAIN_P] = '0;
      register_image[CSR_GAIN_I] = 32'h7FFF_FFFF;
      register_image[CSR_GAIN_D] = 32'h0001_0000;
      register_image[CSR_ERROR_TOL] = '0;
      register_image[CSR_DIFFERENCE_TOL] = '0;
      register_image[CSR_INTEGRATE_MIN] = 32'hFF80_0000;
      register_image[CSR_INTEGRATE_MAX] = 32'h007F_FFFF;
      register_image[CSR_OUTPUT_LIMIT] = 32'h7FFF_FFFF;
      program_registers('1);
      sender_idles = 1'b0;
      receiver_idles = 1'b0;
      hold_output = 1'b1;
      repeat (20) begin
         send_sample(24'sh7F_FFFF);
      end
      wait_for_results();
   endtask

   // Random register settings, each followed by a block of sample runs.
   // Idling on each side is chosen anew at random every 25 samples so that
   // stretches without gaps mix with bursty ones.
   task automatic test_random_settings();
      for (int phase = 0; phase < RandomPhases; phase++) begin
         randomize_registers();
         program_registers('1);
         for (int n = 0; n < PhaseSamples; n++) begin
            if (n % 25 == 0) begin
               sender_idles = 1'($urandom_range(0, 1));
               receiver_idles = 1'($urandom_range(0, 1));
            end
            send_sample(next_error());
         end
         wait_for_results();
      end
   endtask

   // Closing part at full rate: no gaps and no stalls at all.
   task automatic test_full_rate();
      sender_idles = 1'b0;
      receiver_idles = 1'b0;
      repeat (2) begin
         randomize_registers();
         program_registers('1);
         repeat (FullRateSamples) begin
            send_sample(next_error());
         end
         wait_for_results();
      end
   endtask

   // Receiver side: either a requested long hold, a random stall burst, or
   // ready. The hold is counted here, in cycles.
   initial begin : output_side
      int burst;

      forever begin
         @(negedge clock);
         if (hold_output) begin
            hold_output = 1'b0;
            rsp_ready <= 1'b0;
            repeat (OutputHoldCycles - 1) @(negedge clock);
         end else if (receiver_idles && $urandom_range(0, 3) == 0) begin
            burst = $urandom_range(1, 10);
            rsp_ready <= 1'b0;
            repeat (burst - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Every result transfer is matched against the oldest prediction.
   always @(posedge clock) begin : check_drives
      drive_result_type want;

      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_drives.size() == 0) begin
            $error("Result transfer with nothing outstanding: drive %0d", rsp_drive);
            failures++;
         end else begin
            want = pending_drives.pop_front();
            if (rsp_drive !== want.drive) begin
               $error("drive: expected %0d, got %0d", want.drive, rsp_drive);
               failures++;
            end
            if (rsp_at_setpoint !== want.at_setpoint) begin
               $error("at_setpoint: expected %0b, got %0b",
                      want.at_setpoint, rsp_at_setpoint);
               failures++;
            end
            if (rsp_clamped !== want.clamped) begin
               $error("clamped: expected %0b, got %0b", want.clamped, rsp_clamped);
               failures++;
            end
            if (want.clamped) begin
               clamped_seen++;
            end
            if (want.at_setpoint) begin
               setpoint_seen++;
            end
         end
      end
   end

   // Ends the run if no transfer of any kind happens for too long, which is
   // also how a lost or stuck result shows up.
   initial begin : watchdog
      int quiet;

      quiet = 0;
      while (quiet < WatchdogLimit) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("Timeout after %0d quiet cycles with %0d results outstanding.",
               WatchdogLimit, pending_drives.size());
      $display("FAIL pid_controller_step");
      $finish;
   end

   // Reset once, then the tests in turn. Each test leaves the block idle, so
   // the next one can rewrite the registers safely.
   initial begin
      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_first_sample_and_extremes();
      test_window_and_tolerances();
      test_empty_window_zero_limit();
      test_output_hold();
      test_random_settings();
      test_full_rate();

      $display("Checked %0d samples over %0d register settings, with a long output hold.",
               samples_sent, settings_used);
      $display("%0d results were clamped and %0d reported the setpoint as reached.",
               clamped_seen, setpoint_seen);
      if (failures == 0) begin
         $display("PASS pid_controller_step");
      end else begin
         $display("FAIL pid_controller_step");
      end
      $finish;
   end

endmodule

/* files.f */
src/pid_pkg.sv
src/pid_state.sv
src/pid_controller_step.sv
bench/pid_controller_step_test.sv
